### sv/pwm_pulse_width_capture_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef PWM_PULSE_WIDTH_CAPTURE_UNIT_DEFINES_SVH
`define PWM_PULSE_WIDTH_CAPTURE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PWCU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pwcu check failed");

// next-cycle implication, disabled during reset
`define PWCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pwcu check failed");

`endif

### sv/pwcu_pkg.sv
package pwcu_pkg;

   localparam int STICK_COUNT_DEF = 4;

   localparam int IDX_W       = 2;
   localparam int TIME_W      = 16;
   localparam int CNT_W       = 8;
   localparam int SIU_W       = 3;
   localparam int MASK_W      = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CNT_W-1:0] COUNT_SAT = '1;

   // reset values of the control registers
   localparam logic [SIU_W-1:0]  SIU_RST          = 3'd4;
   localparam logic [MASK_W-1:0] INVERT_MASK_RST  = 4'd0;
   localparam logic [TIME_W-1:0] PERIOD_MIN_RST   = 16'd3000;
   localparam logic [TIME_W-1:0] PERIOD_MAX_RST   = 16'd5000;
   localparam logic [TIME_W-1:0] PULSE_MIN_RST    = 16'd80;
   localparam logic [TIME_W-1:0] PULSE_MAX_RST    = 16'd3820;
   localparam logic [CNT_W-1:0]  SAMPLES_RST      = 8'd3;
   localparam logic [TIME_W-1:0] FULL_SCALE_RST   = 16'd4095;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STICKS_IN_USE     = 3'd0,
      CSR_INVERT_MASK       = 3'd1,
      CSR_PERIOD_MIN        = 3'd2,
      CSR_PERIOD_MAX        = 3'd3,
      CSR_PULSE_MIN         = 3'd4,
      CSR_PULSE_MAX         = 3'd5,
      CSR_SAMPLES_NEEDED    = 3'd6,
      CSR_INVERT_FULL_SCALE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SIU_W-1:0]  sticks_in_use;
      logic [MASK_W-1:0] invert_mask;
      logic [TIME_W-1:0] period_min;
      logic [TIME_W-1:0] period_max;
      logic [TIME_W-1:0] pulse_min;
      logic [TIME_W-1:0] pulse_max;
      logic [CNT_W-1:0]  samples_needed;
      logic [TIME_W-1:0] invert_full_scale;
   } cfg_type;

   typedef struct packed {
      logic              all_detected;
      logic              period_rejected;
      logic [CNT_W-1:0]  sample_total;
      logic [TIME_W-1:0] stick_value;
      logic              width_valid;
      logic [IDX_W-1:0]  out_stick;
   } result_type;

endpackage

### sv/pwm_pulse_width_capture_unit.sv
// PWM pulse-width capture for up to STICK_COUNT stick channels. Each req
// transaction is one capture event (stick index plus the 16-bit free-running
// timer value at the edge) and yields exactly one rsp transaction, in order.
// A stick alternates between a rising phase, where the time since its last
// rise is checked against period_min..period_max (out of range clears its
// sample count and flags period_rejected), and a pulse phase, where a width
// strictly between pulse_min and pulse_max is reported (optionally inverted
// against invert_full_scale, floored at zero) and counted, saturating at 255.
// all_detected is high when sticks_in_use is nonzero and each of the first
// sticks_in_use sticks has at least samples_needed valid pulses. Throughput is
// one transaction per clock while rsp_tready holds. The accepting edge loads
// the input register; the per-stick read-modify-write moves the transaction
// into the result register once that is empty or being drained. The per-stick
// state lives in flops, so back-to-back events on the same stick see each
// other's updates with no stall. The user must write control registers through the csr
// port only while no transaction is in flight; the block does not enforce it.
module pwm_pulse_width_capture_unit
   import pwcu_pkg::*;
#(
   parameter int STICK_COUNT = STICK_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] stick_index, [17:2] capture_time, [23:18] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] out_stick, [2] width_valid, [18:3] stick_value, [26:19] sample_total,
   // [27] period_rejected, [28] all_detected, [31:29] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int RES_W = $bits(result_type);

   cfg_type           cfg;
   result_type        result;

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [IDX_W-1:0]  in_idx_ff;
   logic [TIME_W-1:0] in_time_ff;

   // result register
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_data_ff;

   logic              req_fire;
   logic              advance;

   // the stage moves whenever the result register is empty or being drained
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_idx_ff  <= req_tdata[IDX_W-1:0];
         in_time_ff <= req_tdata[IDX_W +: TIME_W];
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   pwcu_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state is committed only when the transaction leaves the input register
   pwcu_stick_engine #(
      .STICK_COUNT (STICK_COUNT)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .stick_index  (in_idx_ff),
      .capture_time (in_time_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RES_W){1'b0}}, out_data_ff};

endmodule

### sv/pwcu_cfg_regs.sv
module pwcu_cfg_regs
   import pwcu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sticks_in_use     <= SIU_RST;
         cfg_ff.invert_mask       <= INVERT_MASK_RST;
         cfg_ff.period_min        <= PERIOD_MIN_RST;
         cfg_ff.period_max        <= PERIOD_MAX_RST;
         cfg_ff.pulse_min         <= PULSE_MIN_RST;
         cfg_ff.pulse_max         <= PULSE_MAX_RST;
         cfg_ff.samples_needed    <= SAMPLES_RST;
         cfg_ff.invert_full_scale <= FULL_SCALE_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_STICKS_IN_USE:     cfg_ff.sticks_in_use     <= csr_wdata[SIU_W-1:0];
            CSR_INVERT_MASK:       cfg_ff.invert_mask       <= csr_wdata[MASK_W-1:0];
            CSR_PERIOD_MIN:        cfg_ff.period_min        <= csr_wdata[TIME_W-1:0];
            CSR_PERIOD_MAX:        cfg_ff.period_max        <= csr_wdata[TIME_W-1:0];
            CSR_PULSE_MIN:         cfg_ff.pulse_min         <= csr_wdata[TIME_W-1:0];
            CSR_PULSE_MAX:         cfg_ff.pulse_max         <= csr_wdata[TIME_W-1:0];
            CSR_SAMPLES_NEEDED:    cfg_ff.samples_needed    <= csr_wdata[CNT_W-1:0];
            CSR_INVERT_FULL_SCALE: cfg_ff.invert_full_scale <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/pwcu_stick_engine.sv
module pwcu_stick_engine
   import pwcu_pkg::*;
#(
   parameter int STICK_COUNT = STICK_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [IDX_W-1:0]  stick_index,
   input  logic [TIME_W-1:0] capture_time,
   input  cfg_type           cfg,
   output result_type        result
);

   // per-stick lanes
   logic [TIME_W-1:0] rise_ff  [STICK_COUNT];
   logic [TIME_W-1:0] rise_in  [STICK_COUNT];
   logic              armed_ff [STICK_COUNT];
   logic              armed_in [STICK_COUNT];
   logic [CNT_W-1:0]  count_ff [STICK_COUNT];
   logic [CNT_W-1:0]  count_in [STICK_COUNT];

   logic              hit;
   logic [TIME_W-1:0] cur_rise;
   logic              cur_armed;
   logic [CNT_W-1:0]  cur_count;
   logic [TIME_W-1:0] diff;
   logic [TIME_W-1:0] new_rise;
   logic              new_armed;
   logic [CNT_W-1:0]  new_count;
   logic              valid;
   logic              rejected;
   logic [TIME_W-1:0] value;
   logic              detected;

   always_comb begin
      hit       = int'(stick_index) < STICK_COUNT;
      cur_rise  = '0;
      cur_armed = 1'b0;
      cur_count = '0;
      for (int i = 0; i < STICK_COUNT; i++) begin
         if (int'(stick_index) == i) begin
            cur_rise  = rise_ff[i];
            cur_armed = armed_ff[i];
            cur_count = count_ff[i];
         end
      end

      diff      = capture_time - cur_rise;
      new_rise  = cur_rise;
      new_armed = cur_armed;
      new_count = cur_count;
      valid     = 1'b0;
      rejected  = 1'b0;
      value     = '0;

      if (cur_armed) begin
         // pulse phase: width is time since the rise
         new_armed = 1'b0;
         if (diff > cfg.pulse_min && diff < cfg.pulse_max) begin
            valid = 1'b1;
            if (cfg.invert_mask[stick_index]) begin
               value = (cfg.invert_full_scale >= diff) ? cfg.invert_full_scale - diff : '0;
            end else begin
               value = diff;
            end
            if (cur_count != COUNT_SAT) begin
               new_count = cur_count + CNT_W'(1);
            end
         end
      end else begin
         // rising phase: period check, rise always stored
         new_rise = capture_time;
         if (diff < cfg.period_min || diff > cfg.period_max) begin
            new_count = '0;
            rejected  = 1'b1;
         end else begin
            new_armed = 1'b1;
         end
      end

      for (int i = 0; i < STICK_COUNT; i++) begin
         rise_in[i]  = rise_ff[i];
         armed_in[i] = armed_ff[i];
         count_in[i] = count_ff[i];
         if (fire && hit && int'(stick_index) == i) begin
            rise_in[i]  = new_rise;
            armed_in[i] = new_armed;
            count_in[i] = new_count;
         end
      end

      // detection sees the counts after this update
      detected = cfg.sticks_in_use != '0;
      for (int i = 0; i < STICK_COUNT; i++) begin
         if (i < int'(cfg.sticks_in_use) && count_in[i] < cfg.samples_needed) begin
            detected = 1'b0;
         end
      end

      result.out_stick       = stick_index;
      result.width_valid     = hit & valid;
      result.stick_value     = hit ? value : '0;
      result.sample_total    = hit ? new_count : '0;
      result.period_rejected = hit & rejected;
      result.all_detected    = detected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STICK_COUNT; i++) begin
            rise_ff[i]  <= '0;
            armed_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
      end else begin
         rise_ff  <= rise_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/pwcu_checker.sv
`include "pwm_pulse_width_capture_unit_defines.svh"

module pwcu_checker
   import pwcu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `PWCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a stick cannot report a width and reject a period in one event
   `PWCU_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_tvalid, !(rsp_tdata[2] && rsp_tdata[27]))

   // no width reported means the value field is zero
   `PWCU_ASSERT_SAME(a_value_zero, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[18:3] == 16'd0)

   // a rejected period leaves the stick with an empty count
   `PWCU_ASSERT_SAME(a_reject_clears, clock, reset, rsp_tvalid && rsp_tdata[27], rsp_tdata[26:19] == 8'd0)

endmodule

bind pwm_pulse_width_capture_unit pwcu_checker u_pwcu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/pwm_pulse_width_capture_unit_test.sv
`timescale 1ns / 100ps

// Testbench for the PWM pulse-width capture unit.
// Capture events go in on the req stream, one result per event comes back on
// the rsp stream. A per-stick model of rise stamp, phase and sample count
// predicts every result at the moment its req transaction is accepted; each
// rsp transaction is compared field by field with the oldest prediction.
module pwm_pulse_width_capture_unit_test;
   import pwcu_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   // Tracks what the unit should hold and the results still owed by it.
   class capture_scoreboard;
      logic [TIME_W-1:0] rise_at [STICK_COUNT_DEF];
      bit                in_pulse [STICK_COUNT_DEF];
      logic [CNT_W-1:0]  pulse_count [STICK_COUNT_DEF];
      cfg_type           cfg;
      result_type        owed_results [$];
      int                errors;

      function new();
         for (int i = 0; i < STICK_COUNT_DEF; i++) begin
            rise_at[i]     = '0;
            in_pulse[i]    = 1'b0;
            pulse_count[i] = '0;
         end
         cfg.sticks_in_use     = SIU_RST;
         cfg.invert_mask       = INVERT_MASK_RST;
         cfg.period_min        = PERIOD_MIN_RST;
         cfg.period_max        = PERIOD_MAX_RST;
         cfg.pulse_min         = PULSE_MIN_RST;
         cfg.pulse_max         = PULSE_MAX_RST;
         cfg.samples_needed    = SAMPLES_RST;
         cfg.invert_full_scale = FULL_SCALE_RST;
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_STICKS_IN_USE:     cfg.sticks_in_use     = v[SIU_W-1:0];
            CSR_INVERT_MASK:       cfg.invert_mask       = v[MASK_W-1:0];
            CSR_PERIOD_MIN:        cfg.period_min        = v;
            CSR_PERIOD_MAX:        cfg.period_max        = v;
            CSR_PULSE_MIN:         cfg.pulse_min         = v;
            CSR_PULSE_MAX:         cfg.pulse_max         = v;
            CSR_SAMPLES_NEEDED:    cfg.samples_needed    = v[CNT_W-1:0];
            CSR_INVERT_FULL_SCALE: cfg.invert_full_scale = v;
            default: ;
         endcase
      endfunction

      function bit sticks_detected();
         int n;
         n = int'(cfg.sticks_in_use);
         if (n == 0) return 1'b0;
         if (n > STICK_COUNT_DEF) n = STICK_COUNT_DEF;
         for (int i = 0; i < n; i++)
            if (pulse_count[i] < cfg.samples_needed) return 1'b0;
         return 1'b1;
      endfunction

      function void record_capture(logic [IDX_W-1:0] s, logic [TIME_W-1:0] t);
         result_type        r;
         logic [TIME_W-1:0] span;
         r = '0;
         r.out_stick = s;
         span = t - rise_at[s];
         if (in_pulse[s]) begin
            if (span > cfg.pulse_min && span < cfg.pulse_max) begin
               r.width_valid = 1'b1;
               if (cfg.invert_mask[s])
                  r.stick_value = (cfg.invert_full_scale >= span) ?
                                  cfg.invert_full_scale - span : '0;
               else
                  r.stick_value = span;
               if (pulse_count[s] != COUNT_SAT) pulse_count[s]++;
            end
            in_pulse[s] = 1'b0;
         end else begin
            if (span < cfg.period_min || span > cfg.period_max) begin
               pulse_count[s]    = '0;
               r.period_rejected = 1'b1;
            end else begin
               in_pulse[s] = 1'b1;
            end
            rise_at[s] = t;
         end
         r.sample_total = pulse_count[s];
         r.all_detected = sticks_detected();
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data);
         result_type got, want;
         got = result_type'(data[$bits(result_type)-1:0]);
         if (owed_results.size() == 0) begin
            $error("unexpected result transaction: tdata %h", data);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("out_stick", want.out_stick, got.out_stick);
         compare_field("width_valid", want.width_valid, got.width_valid);
         compare_field("stick_value", want.stick_value, got.stick_value);
         compare_field("sample_total", want.sample_total, got.sample_total);
         compare_field("period_rejected", want.period_rejected, got.period_rejected);
         compare_field("all_detected", want.all_detected, got.all_detected);
         compare_field("tdata pad", 0, data[RSP_TDATA_W-1:$bits(result_type)]);
      endfunction

      function int owed();
         return owed_results.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [1:0] stick_index, [17:2] capture_time, [23:18] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [1:0] out_stick, [2] width_valid, [18:3] stick_value, [26:19] sample_total,
   // [27] period_rejected, [28] all_detected, [31:29] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   capture_scoreboard sb = new();

   bit idle_on = 1'b1;   // random gaps on both sides; cleared for the last phase
   int hold_ticket = 0;  // bumped by the stimulus to ask for one long rsp hold-off
   int holds_served = 0;
   int cycle_count = 0;

   pwm_pulse_width_capture_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // rsp monitor: signals read right after the edge are their pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Receiver: short random stalls, plus one long hold-off on request so the
   // pipe backs up and req_tready drops while the sender keeps offering.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != hold_ticket) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One capture event; tvalid stays up for a following event unless a gap
   // is drawn, so it is never dropped and raised in the same step.
   task automatic send_event(logic [IDX_W-1:0] s, logic [TIME_W-1:0] t);
      req_tdata  <= {{(REQ_TDATA_W - IDX_W - TIME_W){1'b0}}, t, s};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.record_capture(s, t);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Sender pause until every owed result is back, then a few idle clocks.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.owed() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr_we is lowered by the caller after the last write of a batch
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_register(idx, v);
   endtask

   task automatic write_all(logic [CSR_DATA_W-1:0] siu, logic [CSR_DATA_W-1:0] mask,
                            logic [CSR_DATA_W-1:0] pmin, logic [CSR_DATA_W-1:0] pmax,
                            logic [CSR_DATA_W-1:0] wmin, logic [CSR_DATA_W-1:0] wmax,
                            logic [CSR_DATA_W-1:0] need, logic [CSR_DATA_W-1:0] fs);
      write_csr(CSR_STICKS_IN_USE, siu);
      write_csr(CSR_INVERT_MASK, mask);
      write_csr(CSR_PERIOD_MIN, pmin);
      write_csr(CSR_PERIOD_MAX, pmax);
      write_csr(CSR_PULSE_MIN, wmin);
      write_csr(CSR_PULSE_MAX, wmax);
      write_csr(CSR_SAMPLES_NEEDED, need);
      write_csr(CSR_INVERT_FULL_SCALE, fs);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed rise/fall sequences aimed inside the current windows,
   // the rest window-edge values and plain noise. With a focus stick, that
   // stick only ever sees well-formed events so its count can saturate.
   task automatic run_phase(int count, int focus, int hold_at);
      logic [IDX_W-1:0]  s;
      logic [TIME_W-1:0] t;
      int                lo, hi, pick;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_ticket++;
         if (focus >= 0 && $urandom_range(0, 9) != 0) s = IDX_W'(focus);
         else s = IDX_W'($urandom_range(0, 3));
         t = TIME_W'($urandom);
         if ((focus >= 0 && s == IDX_W'(focus)) || $urandom_range(0, 99) < 75) begin
            if (sb.in_pulse[s]) begin
               lo = int'(sb.cfg.pulse_min) + 1;
               hi = int'(sb.cfg.pulse_max) - 1;
            end else begin
               lo = int'(sb.cfg.period_min);
               hi = int'(sb.cfg.period_max);
            end
            if (lo <= hi) t = TIME_W'(int'(sb.rise_at[s]) + int'($urandom_range(hi, lo)));
         end else if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 6))
               0: pick = int'(sb.cfg.pulse_min);
               1: pick = int'(sb.cfg.pulse_max);
               2: pick = int'(sb.cfg.period_min) - 1;
               3: pick = int'(sb.cfg.period_max) + 1;
               4: pick = int'(sb.cfg.period_min);
               5: pick = int'(sb.cfg.period_max);
               default: pick = 0;
            endcase
            t = TIME_W'(int'(sb.rise_at[s]) + pick);
         end
         send_event(s, t);
      end
   endtask

   // Directed events under reset settings: window edges (exact period limits
   // accepted, exact width maximum refused), timer wrap and period rejects.
   logic [IDX_W-1:0]  dir_stick [17] = '{0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 0, 0};
   logic [TIME_W-1:0] dir_time [17]  = '{3000, 3081, 8000, 11819, 16818, 16898, 19897,
                                         65535, 3999, 7819, 5001, 9001, 9002, 4000, 4100,
                                         23897, 26000};

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 17; i++) send_event(dir_stick[i], dir_time[i]);

      // no stick checked; everything inverted against zero full scale
      drain();
      write_all(0, 15, 3000, 5000, 80, 3820, 0, 0);
      run_phase(200, -1, -1);

      // sticks_in_use above the stick count, open windows, partial inversion;
      // long rsp hold-off in the middle
      drain();
      write_all(7, 5, 0, 16'hFFFF, 0, 16'hFFFF, 2, 2000);
      run_phase(200, -1, 60);

      // one stick driven long enough for its count to saturate
      drain();
      write_all(1, 0, 1000, 1200, 100, 900, 255, 16'hFFFF);
      run_phase(800, 0, -1);

      // single legal period and single legal width
      drain();
      write_all(4, 10, 4000, 4000, 1000, 1002, 1, 1500);
      run_phase(160, -1, -1);

      // raw random register values, narrow fields carry junk in the upper bits
      drain();
      write_all(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      run_phase(160, -1, -1);

      // last part: random but sane windows, no idling on either side
      drain();
      idle_on = 1'b0;
      begin
         logic [CSR_DATA_W-1:0] pmin, wmin;
         pmin = CSR_DATA_W'($urandom_range(0, 20000));
         wmin = CSR_DATA_W'($urandom_range(0, 5000));
         write_all(CSR_DATA_W'($urandom_range(1, 4)), CSR_DATA_W'($urandom_range(0, 15)),
                   pmin, CSR_DATA_W'(int'(pmin) + int'($urandom_range(0, 20000))),
                   wmin, CSR_DATA_W'(int'(wmin) + int'($urandom_range(2, 5000))),
                   CSR_DATA_W'($urandom_range(0, 8)), CSR_DATA_W'($urandom));
      end
      run_phase(160, -1, -1);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.owed() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
